// ===== hw/rtl/bmhpq_pkg.sv =====
// Shared constants, command codes and controller/datapath interface types for the heap queue.
`default_nettype none

package bmhpq_pkg;

  // Heap store geometry.
  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = 7;
  localparam int PW    = 32;
  localparam int TW    = 16;
  localparam int EW    = PW + TW;

  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] CAP_RESET = CW'(64);

  // Configuration register byte address.
  localparam logic [2:0] CFG_ADDR_CAP = 3'd0;

  // Command codes.
  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  // Read address selects.
  localparam logic [2:0] RD_ROOT   = 3'd0;
  localparam logic [2:0] RD_PARENT = 3'd1;
  localparam logic [2:0] RD_LAST   = 3'd2;
  localparam logic [2:0] RD_LEFT   = 3'd3;
  localparam logic [2:0] RD_RIGHT  = 3'd4;

  // Write data selects.
  localparam logic [1:0] WR_X    = 2'd0;
  localparam logic [1:0] WR_RD   = 2'd1;
  localparam logic [1:0] WR_BEST = 2'd2;

  typedef struct packed {
    logic       ld;
    logic       ok_load;
    logic       ok_val;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       p_tail;
    logic       p_root;
    logic       p_parent;
    logic       p_best;
    logic [2:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       x_from_rd;
    logic       l_from_rd;
    logic       done;
  } bmhpq_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       enq_ok;
    logic       deq_ok;
    logic       p_is_root;
    logic       up_go;
    logic       left_out;
    logic       down_go;
  } bmhpq_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/binary_max_heap_priority_queue.sv =====
// Top level of the bounded max-priority queue: configuration register, controller and datapath.
`default_nettype none

// A bounded max-priority queue kept as a binary heap in a 64-entry RAM.
// A command transaction is accepted on a rising edge where start is high and
// busy is low; in_cmd selects enqueue, dequeue or peek, and in_priority_req
// and in_payload give the entry to enqueue. Every transaction produces exactly
// one result transaction: out_valid is high for one cycle with the success
// flag, the current top entry (priority -1 and payload 0 when empty), the
// count and the empty and full flags. The receiver cannot stall the result.
// One item is worked on at a time. The heap RAM has a single read port and
// every heap level costs a read, a compare and a write-back; a peek or a
// refused command only reads the root, an enqueue climbs the heap and a
// dequeue descends it. busy drops in the cycle the result is shown, so the
// next command may be accepted alongside it. Reset (synchronous, rst_n low)
// empties the queue and sets capacity_limit to 64; the RAM is not cleared,
// since only written entries are ever read. capacity_limit is written over
// the APB port at byte address 0; the user must do so only while idle, as
// the block itself does not enforce it.
module binary_max_heap_priority_queue (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      in_cmd,
  input  wire logic signed [bmhpq_pkg::PW-1:0] in_priority_req,
  input  wire logic [bmhpq_pkg::TW-1:0]        in_payload,
  output logic                                 out_valid,
  output logic                                 out_ok,
  output logic signed [bmhpq_pkg::PW-1:0]      out_top_priority,
  output logic [bmhpq_pkg::TW-1:0]             out_top_payload,
  output logic [bmhpq_pkg::CW-1:0]             out_count,
  output logic                                 out_is_empty,
  output logic                                 out_is_full,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [2:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int CW = bmhpq_pkg::CW;

  logic [CW-1:0]         cap_r;
  logic                  cfg_wr;
  bmhpq_pkg::bmhpq_ctl_t ctl;
  bmhpq_pkg::bmhpq_sts_t sts;

  // The capacity register takes a write in the access phase of an APB
  // transaction; addresses other than the capacity register are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == bmhpq_pkg::CFG_ADDR_CAP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= bmhpq_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[CW-1:0];
    end
  end

  // Reads return the capacity register at its address and zero elsewhere.
  assign prdata = (paddr == bmhpq_pkg::CFG_ADDR_CAP) ? {(32-CW)'(0), cap_r} : 32'd0;

  // The controller walks the heap one level at a time and tells the
  // datapath which RAM address to read, what to write back and where the
  // walk moves; the datapath reports the compare outcomes.
  bmhpq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  bmhpq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .cap              (cap_r),
    .in_cmd           (in_cmd),
    .in_priority_req  (in_priority_req),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_top_priority (out_top_priority),
    .out_top_payload  (out_top_payload),
    .out_count        (out_count),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full)
  );

  // A result strobe lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // An accepted command keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not make the block busy");

  // The empty flag agrees with the reported count.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == '0)))
    else $error("empty flag disagrees with count");

  // The count never exceeds the heap depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= bmhpq_pkg::DEPTH_CNT))
    else $error("count exceeds heap depth");

  // An empty queue reports the empty sentinel as its top entry.
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_top_priority == -32'sd1 && out_top_payload == '0))
    else $error("empty queue reported a top entry");

endmodule

`default_nettype wire

// ===== hw/rtl/bmhpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bmhpq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bmhpq_dp.sv =====
// Datapath of the heap queue: entry count, walk position, held entries, heap RAM and result registers.
`default_nettype none

module bmhpq_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bmhpq_pkg::bmhpq_ctl_t       ctl,
  output bmhpq_pkg::bmhpq_sts_t            sts,
  input  wire logic [bmhpq_pkg::CW-1:0]    cap,
  input  wire logic [1:0]                  in_cmd,
  input  wire logic signed [bmhpq_pkg::PW-1:0] in_priority_req,
  input  wire logic [bmhpq_pkg::TW-1:0]    in_payload,
  output logic                             out_valid,
  output logic                             out_ok,
  output logic signed [bmhpq_pkg::PW-1:0]  out_top_priority,
  output logic [bmhpq_pkg::TW-1:0]         out_top_payload,
  output logic [bmhpq_pkg::CW-1:0]         out_count,
  output logic                             out_is_empty,
  output logic                             out_is_full
);

  localparam int AW = bmhpq_pkg::AW;
  localparam int CW = bmhpq_pkg::CW;
  localparam int PW = bmhpq_pkg::PW;
  localparam int TW = bmhpq_pkg::TW;
  localparam int EW = bmhpq_pkg::EW;

  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        p_r, p_nxt;
  logic [1:0]           cmd_r;
  logic signed [PW-1:0] x_prio_r;
  logic [TW-1:0]        x_tag_r;
  logic signed [PW-1:0] l_prio_r;
  logic [TW-1:0]        l_tag_r;
  logic                 ok_r;
  logic                 out_valid_r;
  logic                 out_ok_r;
  logic signed [PW-1:0] out_prio_r;
  logic [TW-1:0]        out_tag_r;
  logic [CW-1:0]        out_count_r;
  logic                 out_empty_r;
  logic                 out_full_r;

  logic [CW-1:0]        cap_eff;
  logic [CW:0]          pos_l, pos_r, count_ext, best_pos;
  logic [EW-1:0]        rdata, wdata;
  logic signed [PW-1:0] rd_prio, best_prio;
  logic [TW-1:0]        rd_tag, best_tag;
  logic                 right_in, right_sel;
  logic [AW-1:0]        raddr, waddr;
  logic [CW-1:0]        parent_pos;

  assign cap_eff   = (cap > bmhpq_pkg::DEPTH_CNT) ? bmhpq_pkg::DEPTH_CNT : cap;
  assign pos_l     = {p_r, 1'b0};
  assign pos_r     = pos_l + (CW+1)'(1);
  assign count_ext = {1'b0, count_r};
  assign parent_pos = p_r >> 1;

  assign rd_prio = $signed(rdata[EW-1:TW]);
  assign rd_tag  = rdata[TW-1:0];

  // Left child wins a tie; the right child counts only when it exists.
  assign right_in  = pos_r <= count_ext;
  assign right_sel = right_in && (rd_prio > l_prio_r);
  assign best_prio = right_sel ? rd_prio : l_prio_r;
  assign best_tag  = right_sel ? rd_tag : l_tag_r;
  assign best_pos  = right_sel ? pos_r : pos_l;

  assign sts.cmd       = cmd_r;
  assign sts.enq_ok    = count_r < cap_eff;
  assign sts.deq_ok    = count_r != '0;
  assign sts.p_is_root = p_r == CW'(1);
  assign sts.up_go     = rd_prio < x_prio_r;
  assign sts.left_out  = pos_l > count_ext;
  assign sts.down_go   = best_prio > x_prio_r;

  always_comb begin
    case (ctl.rd_sel)
      bmhpq_pkg::RD_ROOT:   raddr = '0;
      bmhpq_pkg::RD_PARENT: raddr = AW'(parent_pos - CW'(1));
      bmhpq_pkg::RD_LAST:   raddr = AW'(count_r - CW'(1));
      bmhpq_pkg::RD_LEFT:   raddr = AW'(pos_l - (CW+1)'(1));
      bmhpq_pkg::RD_RIGHT:  raddr = AW'(pos_l);
      default:              raddr = '0;
    endcase
  end

  assign waddr = AW'(p_r - CW'(1));

  always_comb begin
    case (ctl.wr_sel)
      bmhpq_pkg::WR_X:    wdata = {x_prio_r, x_tag_r};
      bmhpq_pkg::WR_RD:   wdata = rdata;
      bmhpq_pkg::WR_BEST: wdata = {best_prio, best_tag};
      default:            wdata = {x_prio_r, x_tag_r};
    endcase
  end

  bmhpq_ram #(
    .WIDTH (EW),
    .DEPTH (bmhpq_pkg::DEPTH)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    count_nxt = count_r;
    if (ctl.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    p_nxt = p_r;
    if (ctl.p_tail) begin
      p_nxt = count_r + CW'(1);
    end else if (ctl.p_root) begin
      p_nxt = CW'(1);
    end else if (ctl.p_parent) begin
      p_nxt = parent_pos;
    end else if (ctl.p_best) begin
      p_nxt = CW'(best_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= ctl.done;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (ctl.ld) begin
      cmd_r    <= in_cmd;
      x_prio_r <= in_priority_req;
      x_tag_r  <= in_payload;
    end else if (ctl.x_from_rd) begin
      x_prio_r <= rd_prio;
      x_tag_r  <= rd_tag;
    end
    if (ctl.l_from_rd) begin
      l_prio_r <= rd_prio;
      l_tag_r  <= rd_tag;
    end
    if (ctl.ok_load) begin
      ok_r <= ctl.ok_val;
    end
    if (ctl.done) begin
      out_ok_r    <= ok_r;
      out_count_r <= count_r;
      out_empty_r <= count_r == '0;
      out_full_r  <= count_r >= cap_eff;
      if (count_r == '0) begin
        out_prio_r <= -PW'(1);
        out_tag_r  <= '0;
      end else begin
        out_prio_r <= rd_prio;
        out_tag_r  <= rd_tag;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_top_priority = out_prio_r;
  assign out_top_payload  = out_tag_r;
  assign out_count        = out_count_r;
  assign out_is_empty     = out_empty_r;
  assign out_is_full      = out_full_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bmhpq_ctrl.sv =====
// Controller state machine that sequences enqueue sift-up, dequeue sift-down and the root read.
`default_nettype none

module bmhpq_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire bmhpq_pkg::bmhpq_sts_t sts,
  output bmhpq_pkg::bmhpq_ctl_t      ctl,
  output logic                       busy
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_UP_CHK  = 4'd2;
  localparam logic [3:0] S_UP_CMP  = 4'd3;
  localparam logic [3:0] S_DQ_WAIT = 4'd4;
  localparam logic [3:0] S_DN_CHK  = 4'd5;
  localparam logic [3:0] S_DN_RDR  = 4'd6;
  localparam logic [3:0] S_DN_CMP  = 4'd7;
  localparam logic [3:0] S_TOP_RD  = 4'd8;
  localparam logic [3:0] S_TOP_OUT = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       is_enq, is_deq, is_peek;

  assign is_enq  = sts.cmd == bmhpq_pkg::CMD_ENQ;
  assign is_deq  = sts.cmd == bmhpq_pkg::CMD_DEQ;
  assign is_peek = sts.cmd == bmhpq_pkg::CMD_PEEK;

  always_comb begin
    ctl        = '0;
    ctl.rd_sel = bmhpq_pkg::RD_ROOT;
    ctl.wr_sel = bmhpq_pkg::WR_X;
    state_nxt  = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.ld    = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        ctl.ok_load = 1'b1;
        ctl.ok_val  = (is_enq && sts.enq_ok) || (is_deq && sts.deq_ok) || is_peek;
        if (is_enq && sts.enq_ok) begin
          ctl.cnt_inc = 1'b1;
          ctl.p_tail  = 1'b1;
          state_nxt   = S_UP_CHK;
        end else if (is_deq && sts.deq_ok) begin
          ctl.rd_sel  = bmhpq_pkg::RD_LAST;
          ctl.cnt_dec = 1'b1;
          ctl.p_root  = 1'b1;
          state_nxt   = S_DQ_WAIT;
        end else begin
          state_nxt = S_TOP_RD;
        end
      end
      S_UP_CHK: begin
        if (sts.p_is_root) begin
          ctl.wr_en = 1'b1;
          state_nxt = S_TOP_RD;
        end else begin
          ctl.rd_sel = bmhpq_pkg::RD_PARENT;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ctl.wr_en = 1'b1;
        if (sts.up_go) begin
          ctl.wr_sel   = bmhpq_pkg::WR_RD;
          ctl.p_parent = 1'b1;
          state_nxt    = S_UP_CHK;
        end else begin
          state_nxt = S_TOP_RD;
        end
      end
      S_DQ_WAIT: begin
        ctl.x_from_rd = 1'b1;
        state_nxt     = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (sts.left_out) begin
          ctl.wr_en = 1'b1;
          state_nxt = S_TOP_RD;
        end else begin
          ctl.rd_sel = bmhpq_pkg::RD_LEFT;
          state_nxt  = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        ctl.l_from_rd = 1'b1;
        ctl.rd_sel    = bmhpq_pkg::RD_RIGHT;
        state_nxt     = S_DN_CMP;
      end
      S_DN_CMP: begin
        ctl.wr_en = 1'b1;
        if (sts.down_go) begin
          ctl.wr_sel = bmhpq_pkg::WR_BEST;
          ctl.p_best = 1'b1;
          state_nxt  = S_DN_CHK;
        end else begin
          state_nxt = S_TOP_RD;
        end
      end
      S_TOP_RD: begin
        ctl.rd_sel = bmhpq_pkg::RD_ROOT;
        state_nxt  = S_TOP_OUT;
      end
      S_TOP_OUT: begin
        ctl.done  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

`default_nettype wire
